[rtl/taop_pkg.sv]
package taop_pkg;

    localparam int MAX_STEPS = 64;
    localparam int PRICE_W   = 32;
    localparam int NODE_CNT  = 2 * MAX_STEPS + 1;
    localparam int ADDR_W    = $clog2(NODE_CNT);
    localparam int STEP_W    = 7;
    localparam int PROD_W    = 2 * PRICE_W;

    localparam logic [2:0] CFG_PROB_UP   = 3'd0;
    localparam logic [2:0] CFG_PROB_MID  = 3'd1;
    localparam logic [2:0] CFG_PROB_DOWN = 3'd2;
    localparam logic [2:0] CFG_DISCOUNT  = 3'd3;
    localparam logic [2:0] CFG_UP        = 3'd4;
    localparam logic [2:0] CFG_DOWN      = 3'd5;
    localparam logic [2:0] CFG_STEPS     = 3'd6;

    typedef logic [PRICE_W-1:0] t_price;

    // multiplier operand pair
    typedef struct packed {
        t_price a;
        t_price b;
    } t_mul_req;

    // payoff of exercising now
    function automatic t_price f_intrinsic(input t_price s, input t_price k,
                                           input logic put);
        t_price r;
        r = '0;
        if (put) begin
            if (k > s) r = k - s;
        end else begin
            if (s > k) r = s - k;
        end
        return r;
    endfunction

endpackage

[rtl/trinomial_american_option_pricer.sv]
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: spot, strike; tuser: is_put
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: option_value; tuser: overflow
// cfg       in   i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// One transaction at a time; a single registered 32x32 multiplier does all
// the work. Leaf build: the center leaf, then up and down leaves outward.
// Backward walk over N*N nodes: read, three products, sum, discount, write.
// Reset (synchronous, active low) resets control and config; the price and
// value memories need no clearing. A finished result waits in the output
// register; the next request is taken meanwhile, and the block stalls only
// when a second result is ready before the first is taken.
module trinomial_american_option_pricer
    import taop_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] spot_price, [63:32] strike_price
    input  logic        s_axis_tuser,   // [0] is_put
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] option_value
    output logic        m_axis_tuser,   // [0] overflow
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_LEAF0 = 14'b00000000000010,
        S_LMU   = 14'b00000000000100,
        S_LWU   = 14'b00000000001000,
        S_LMD   = 14'b00000000010000,
        S_LWD   = 14'b00000000100000,
        S_NRA   = 14'b00000001000000,
        S_NM0   = 14'b00000010000000,
        S_NM1   = 14'b00000100000000,
        S_NM2   = 14'b00001000000000,
        S_NAC   = 14'b00010000000000,
        S_NDS   = 14'b00100000000000,
        S_NWR   = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } t_state;

    // config registers
    t_price r_pu, r_pm, r_pd, r_df, r_up, r_dn;
    logic [STEP_W-1:0] r_steps;

    t_state r_state, n_state;
    t_price r_spot, r_strike;
    logic   r_put;
    logic   r_ovf;
    logic [STEP_W-1:0] r_n;     // clamped step count
    logic [STEP_W-1:0] r_j;     // leaf distance from center
    logic [STEP_W-1:0] r_lvl;
    logic [ADDR_W-1:0] r_i;
    t_price r_up_p, r_dn_p;     // price chain heads
    t_price r_ex;
    logic [PROD_W+1:0] r_acc;
    t_price r_root;             // last node written, the root at the end
    t_price r_res;
    logic   r_res_ovf;
    logic   r_oval;

    t_price r_leaf_mem [NODE_CNT];
    t_price r_node_mem [NODE_CNT];
    t_price r_leaf_q, r_node_q;

    t_mul_req          w_mreq;
    logic [PROD_W-1:0] w_prod;

    taop_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mreq),
        .o_prod (w_prod)
    );

    logic [STEP_W-1:0] w_n_clamp;
    always_comb begin
        w_n_clamp = r_steps;
        if (r_steps == '0) w_n_clamp = STEP_W'(1);
        if (r_steps > STEP_W'(MAX_STEPS)) w_n_clamp = STEP_W'(MAX_STEPS);
    end

    wire w_in_acc  = s_axis_tvalid && s_axis_tready;
    wire w_out_acc = m_axis_tvalid && m_axis_tready;

    // rounding/saturation of product register
    logic [PROD_W:0]   w_rnd30, w_rnd29;
    logic [PROD_W-30:0] w_up_raw;   // (prod + 2^29) >> 30
    logic [PROD_W-31:0] w_h31;      // (prod + 2^30) >> 31
    t_price w_up_sat, w_h_sat, w_e_sat, w_hold, w_best;
    logic   w_up_ov, w_h_ov, w_e_ov;
    always_comb begin
        w_rnd29  = {1'b0, w_prod} + (PROD_W+1)'(1 << 29);
        w_rnd30  = {1'b0, w_prod} + (PROD_W+1)'(1 << 30);
        w_up_raw = w_rnd29[PROD_W:30];
        w_h31    = w_rnd30[PROD_W:31];
        w_up_ov  = |w_up_raw[PROD_W-30:PRICE_W];
        w_h_ov   = |w_h31[PROD_W-31:PRICE_W];
        w_e_ov   = |r_acc[PROD_W+1:PRICE_W+31];
        w_up_sat = w_up_ov ? '1 : w_up_raw[PRICE_W-1:0];
        w_h_sat  = w_h_ov  ? '1 : w_h31[PRICE_W-1:0];
        w_e_sat  = w_e_ov  ? '1 : r_acc[PRICE_W+30:31];
        w_hold   = w_h_sat;
        w_best   = (w_hold > r_ex) ? w_hold : r_ex;
    end

    // multiplier operand select
    always_comb begin
        w_mreq = '{a: r_node_q, b: r_pu};
        case (r_state)
            S_LMU:   w_mreq = '{a: r_up_p,  b: r_up};
            S_LMD:   w_mreq = '{a: r_dn_p,  b: r_dn};
            S_NM0:   w_mreq = '{a: r_node_q, b: r_pu};
            S_NM1:   w_mreq = '{a: r_node_q, b: r_pm};
            S_NM2:   w_mreq = '{a: r_node_q, b: r_pd};
            S_NDS:   w_mreq = '{a: w_e_sat,  b: r_df};
            default: w_mreq = '{a: r_node_q, b: r_pu};
        endcase
    end

    // memory addressing
    logic [ADDR_W-1:0] w_center, w_wr_addr, w_node_ra, w_leaf_ra;
    logic   w_we;
    t_price w_leaf_wd, w_node_wd;
    always_comb begin
        w_center  = ADDR_W'(r_n);
        w_we      = 1'b0;
        w_wr_addr = w_center;
        w_leaf_wd = r_spot;
        w_node_wd = f_intrinsic(r_spot, r_strike, r_put);
        case (r_state)
            S_LEAF0: w_we = 1'b1;
            S_LWU: begin
                w_we      = 1'b1;
                w_wr_addr = w_center - ADDR_W'(r_j);
                w_leaf_wd = w_up_sat;
                w_node_wd = f_intrinsic(w_up_sat, r_strike, r_put);
            end
            S_LWD: begin
                w_we      = 1'b1;
                w_wr_addr = w_center + ADDR_W'(r_j);
                w_leaf_wd = w_h_sat;
                w_node_wd = f_intrinsic(w_h_sat, r_strike, r_put);
            end
            default: ;
        endcase
        w_node_ra = r_i;
        case (r_state)
            S_NM0:   w_node_ra = r_i + ADDR_W'(1);
            S_NM1:   w_node_ra = r_i + ADDR_W'(2);
            default: w_node_ra = r_i;
        endcase
        w_leaf_ra = r_i + ADDR_W'(r_n) - ADDR_W'(r_lvl);
    end

    always_ff @(posedge i_clk) begin
        if (w_we) r_leaf_mem[w_wr_addr] <= w_leaf_wd;
        r_leaf_q <= r_leaf_mem[w_leaf_ra];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_node_mem[w_wr_addr] <= w_node_wd;
        end else if (r_state == S_NWR) begin
            r_node_mem[r_i] <= w_best;
        end
        r_node_q <= r_node_mem[w_node_ra];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_LEAF0;
            S_LEAF0: n_state = S_LMU;
            S_LMU:   n_state = S_LWU;
            S_LWU:   n_state = S_LMD;
            S_LMD:   n_state = S_LWD;
            S_LWD:   n_state = (r_j == r_n) ? S_NRA : S_LMU;
            S_NRA:   n_state = S_NM0;
            S_NM0:   n_state = S_NM1;
            S_NM1:   n_state = S_NM2;
            S_NM2:   n_state = S_NAC;
            S_NAC:   n_state = S_NDS;
            S_NDS:   n_state = S_NWR;
            S_NWR: begin
                if (r_i == ADDR_W'({r_lvl, 1'b0}) && r_lvl == '0) n_state = S_DONE;
                else n_state = S_NRA;
            end
            S_DONE:  if (!r_oval || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
            r_pu    <= 32'd715827883;
            r_pm    <= 32'd715827882;
            r_pd    <= 32'd715827883;
            r_df    <= 32'd2147483648;
            r_up    <= 32'd1073741824;
            r_dn    <= 32'd2147483648;
            r_steps <= STEP_W'(MAX_STEPS);
            r_j     <= '0;
            r_lvl   <= '0;
            r_i     <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PROB_UP:   r_pu <= i_cfg_data;
                    CFG_PROB_MID:  r_pm <= i_cfg_data;
                    CFG_PROB_DOWN: r_pd <= i_cfg_data;
                    CFG_DISCOUNT:  r_df <= i_cfg_data;
                    CFG_UP:        r_up <= i_cfg_data;
                    CFG_DOWN:      r_dn <= i_cfg_data;
                    CFG_STEPS:     r_steps <= i_cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            // a new result may replace one taken in the same cycle
            if (r_state == S_DONE && (!r_oval || m_axis_tready)) r_oval <= 1'b1;
            else if (w_out_acc) r_oval <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_ovf <= 1'b0;
                    r_j   <= STEP_W'(1);
                end
                S_LWU: if (w_up_ov) r_ovf <= 1'b1;
                S_LWD: begin
                    if (w_h_ov) r_ovf <= 1'b1;
                    r_j   <= r_j + STEP_W'(1);
                    r_lvl <= r_n - STEP_W'(1);
                    r_i   <= '0;
                end
                S_NDS: if (w_e_ov) r_ovf <= 1'b1;
                S_NWR: begin
                    if (w_h_ov) r_ovf <= 1'b1;
                    if (r_i == ADDR_W'({r_lvl, 1'b0})) begin
                        r_i <= '0;
                        if (r_lvl != '0) r_lvl <= r_lvl - STEP_W'(1);
                    end else begin
                        r_i <= r_i + ADDR_W'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_spot   <= s_axis_tdata[31:0];
                r_strike <= s_axis_tdata[63:32];
                r_put    <= s_axis_tuser;
                r_n      <= w_n_clamp;
            end
            S_LEAF0: begin
                r_up_p <= r_spot;
                r_dn_p <= r_spot;
            end
            S_LWU: r_up_p <= w_up_sat;
            S_LWD: r_dn_p <= w_h_sat;
            S_NM0: r_ex <= f_intrinsic(r_leaf_q, r_strike, r_put);
            S_NM1: r_acc <= (PROD_W+2)'(w_prod) + (PROD_W+2)'(1 << 30);
            S_NM2: r_acc <= r_acc + (PROD_W+2)'(w_prod);
            S_NAC: r_acc <= r_acc + (PROD_W+2)'(w_prod);
            S_NWR: r_root <= w_best;
            S_DONE: begin
                if (!r_oval || m_axis_tready) begin
                    r_res     <= r_root;
                    r_res_ovf <= r_ovf;
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_oval;
    assign m_axis_tdata  = r_res;
    assign m_axis_tuser  = r_res_ovf;

`ifndef NO_ASSERTIONS
    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state)) else $error("state not one-hot");
    a_node_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NRA) |-> (r_i <= ADDR_W'({r_lvl, 1'b0})))
        else $error("node index past level");
    a_leaf_rng: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LWU || r_state == S_LWD) |-> (r_j <= r_n && r_j != '0))
        else $error("leaf index out of range");
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && n_state == S_IDLE) |=> m_axis_tvalid)
        else $error("result not presented");
`endif

endmodule

[rtl/taop_mul.sv]
module taop_mul
    import taop_pkg::*;
(
    input  logic              i_clk,
    input  t_mul_req          i_req,
    output logic [PROD_W-1:0] o_prod
);

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_req.a) * PROD_W'(i_req.b);
    end

    assign o_prod = r_prod;

endmodule
